>>> rtl/ikpt_pkg.sv
// shared types, codes and defaults for the input key and pointer tracker
`default_nettype none

package ikpt_pkg;

    localparam int KEY_COUNT_DEF      = 256;
    localparam int JOYSTICK_COUNT_DEF = 8;
    localparam int TOUCH_COUNT_DEF    = 10;

    localparam int COORD_W = 32;
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 32;

    typedef enum logic [2:0] {
        OP_KEY        = 3'd0,
        OP_MOUSE_MOVE = 3'd1,
        OP_MOUSE_SET  = 3'd2,
        OP_TOUCH_DOWN = 3'd3,
        OP_TOUCH_MOVE = 3'd4,
        OP_TOUCH_UP   = 3'd5,
        OP_READ_KEY   = 3'd6,
        OP_READ_POS   = 3'd7
    } op_t;

    localparam logic [1:0] KIND_MOUSE_KBD = 2'd0;
    localparam logic [1:0] KIND_JOYSTICK  = 2'd1;
    localparam logic [1:0] KIND_TOUCH     = 2'd2;

    localparam logic [1:0] ERR_OK             = 2'd0;
    localparam logic [1:0] ERR_TOUCH_NOT_DOWN = 2'd1;
    localparam logic [1:0] ERR_RANGE          = 2'd2;

    localparam logic [1:0] KS_RELEASED = 2'd0;
    localparam logic [1:0] KS_PRESSED  = 2'd1;
    localparam logic [1:0] KS_REPEATED = 2'd2;

    typedef struct packed {
        logic load;
        logic clear_step;
        logic finish;
    } ikpt_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_busy;
    } ikpt_status_t;

endpackage

`default_nettype wire

>>> rtl/ikpt_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module ikpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/ikpt_ctrl.sv
// controller: clearing pass, accept, execute and result handoff
`default_nettype none

module ikpt_ctrl import ikpt_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output ikpt_cmd_t         cmd,
    input  wire ikpt_status_t status
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.clear_step = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold the item until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            in_stall_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

`default_nettype wire

>>> rtl/ikpt_datapath.sv
// datapath: key memory, mouse and touch registers, result register
`default_nettype none

module ikpt_datapath import ikpt_pkg::*; #(
    parameter int KEY_COUNT      = KEY_COUNT_DEF,
    parameter int JOYSTICK_COUNT = JOYSTICK_COUNT_DEF,
    parameter int TOUCH_COUNT    = TOUCH_COUNT_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire ikpt_cmd_t                 cmd,
    output ikpt_status_t                   status,
    input  wire logic [2:0]                operation,
    input  wire logic [1:0]                device_kind,
    input  wire logic [3:0]                device_number,
    input  wire logic [7:0]                key_code,
    input  wire logic                      key_pressed,
    input  wire logic [TIME_W-1:0]         event_time,
    input  wire logic signed [COORD_W-1:0] x_value,
    input  wire logic signed [COORD_W-1:0] y_value,
    input  wire logic                      out_stall,
    output logic                           out_valid,
    output logic [1:0]                     key_state_out,
    output logic [COUNT_W-1:0]             change_count,
    output logic [TIME_W-1:0]              time_out,
    output logic signed [COORD_W-1:0]      pos_x,
    output logic signed [COORD_W-1:0]      pos_y,
    output logic                           pos_valid,
    output logic [1:0]                     error_code
);

    localparam int DEPTH  = (1 + JOYSTICK_COUNT) * KEY_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WORD_W = 1 + COUNT_W + TIME_W;
    localparam int TS_W   = (TOUCH_COUNT > 1) ? $clog2(TOUCH_COUNT) : 1;

    // key table address from the input ports
    logic              key_ok;
    logic [ADDR_W-1:0] tbl_sel;
    logic [ADDR_W-1:0] key_addr;

    always_comb
    begin
        tbl_sel  = (device_kind == KIND_MOUSE_KBD) ? '0
                   : ADDR_W'(device_number) + ADDR_W'(1);
        key_addr = tbl_sel * ADDR_W'(KEY_COUNT) + ADDR_W'(key_code);
        key_ok   = (int'(key_code) < KEY_COUNT)
                   && ((device_kind == KIND_MOUSE_KBD)
                       || ((device_kind == KIND_JOYSTICK)
                           && (int'(device_number) < JOYSTICK_COUNT)));
    end

    // captured transaction
    op_t                op_reg;
    logic [1:0]         kind_reg;
    logic [3:0]         slot_reg;
    logic               key_ok_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               press_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg     <= op_t'(operation);
            kind_reg   <= device_kind;
            slot_reg   <= device_number;
            key_ok_reg <= key_ok;
            addr_reg   <= key_addr;
            press_reg  <= key_pressed;
            time_reg   <= event_time;
            x_reg      <= x_value;
            y_reg      <= y_value;
        end
    end

    // clearing pass over the key memory after reset
    logic [ADDR_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_step)
        begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // key memory word: pressed, change count, time stamp
    logic               key_we;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [WORD_W-1:0]  ram_wdata;
    logic [WORD_W-1:0]  ram_rdata;
    logic               rd_pressed;
    logic [COUNT_W-1:0] rd_count;
    logic [TIME_W-1:0]  rd_time;
    logic [COUNT_W-1:0] new_count;

    assign rd_pressed = ram_rdata[WORD_W-1];
    assign rd_count   = ram_rdata[COUNT_W+TIME_W-1:TIME_W];
    assign rd_time    = ram_rdata[TIME_W-1:0];
    // a change or a press while pressed both bump the count
    assign new_count  = (rd_pressed || press_reg) ? rd_count + COUNT_W'(1) : rd_count;

    assign ram_we    = cmd.clear_step || (cmd.finish && key_we);
    assign ram_waddr = cmd.clear_step ? clr_cnt_reg : addr_reg;
    assign ram_wdata = cmd.clear_step ? '0 : {press_reg, new_count, time_reg};

    ikpt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (key_addr),
        .rdata (ram_rdata)
    );

    // pointer state
    logic [COORD_W-1:0]     mouse_x_reg;
    logic [COORD_W-1:0]     mouse_y_reg;
    logic                   mouse_present_reg;
    logic [COORD_W-1:0]     touch_x_reg [TOUCH_COUNT];
    logic [COORD_W-1:0]     touch_y_reg [TOUCH_COUNT];
    logic [TOUCH_COUNT-1:0] touch_present_reg;

    logic               slot_ok;
    logic [TS_W-1:0]    slot_idx;
    logic [COORD_W-1:0] sel_x;
    logic [COORD_W-1:0] sel_y;
    logic               sel_present;

    always_comb
    begin
        slot_ok     = int'(slot_reg) < TOUCH_COUNT;
        slot_idx    = slot_reg[TS_W-1:0];
        sel_x       = slot_ok ? touch_x_reg[slot_idx] : '0;
        sel_y       = slot_ok ? touch_y_reg[slot_idx] : '0;
        sel_present = slot_ok ? touch_present_reg[slot_idx] : 1'b0;
    end

    // result and state updates
    logic               mouse_upd;
    logic [COORD_W-1:0] mouse_x_new;
    logic [COORD_W-1:0] mouse_y_new;
    logic               touch_upd;
    logic [COORD_W-1:0] touch_x_new;
    logic [COORD_W-1:0] touch_y_new;
    logic               touch_present_new;
    logic [1:0]         res_state;
    logic [COUNT_W-1:0] res_count;
    logic [TIME_W-1:0]  res_time;
    logic [COORD_W-1:0] res_x;
    logic [COORD_W-1:0] res_y;
    logic               res_valid;
    logic [1:0]         res_err;

    always_comb
    begin
        key_we            = 1'b0;
        mouse_upd         = 1'b0;
        mouse_x_new       = x_reg;
        mouse_y_new       = y_reg;
        touch_upd         = 1'b0;
        touch_x_new       = x_reg;
        touch_y_new       = y_reg;
        touch_present_new = 1'b1;
        res_state         = KS_RELEASED;
        res_count         = '0;
        res_time          = '0;
        res_x             = '0;
        res_y             = '0;
        res_valid         = 1'b0;
        res_err           = ERR_OK;
        case (op_reg)
            OP_KEY:
            begin
                if (!key_ok_reg)
                begin
                    res_err = ERR_RANGE;
                end
                else
                begin
                    key_we    = 1'b1;
                    res_state = (rd_pressed && press_reg) ? KS_REPEATED
                                : (press_reg ? KS_PRESSED : KS_RELEASED);
                    res_count = new_count;
                    res_time  = time_reg;
                end
            end
            OP_MOUSE_MOVE:
            begin
                mouse_upd = 1'b1;
                if (mouse_present_reg)
                begin
                    mouse_x_new = mouse_x_reg + x_reg;
                    mouse_y_new = mouse_y_reg + y_reg;
                end
                res_x     = mouse_x_new;
                res_y     = mouse_y_new;
                res_valid = 1'b1;
            end
            OP_MOUSE_SET:
            begin
                mouse_upd = 1'b1;
                res_x     = x_reg;
                res_y     = y_reg;
                res_valid = 1'b1;
            end
            OP_TOUCH_DOWN:
            begin
                if (!slot_ok)
                begin
                    res_err = ERR_RANGE;
                end
                else
                begin
                    touch_upd = 1'b1;
                    res_x     = x_reg;
                    res_y     = y_reg;
                    res_valid = 1'b1;
                end
            end
            OP_TOUCH_MOVE:
            begin
                if (!slot_ok)
                begin
                    res_err = ERR_RANGE;
                end
                else if (!sel_present)
                begin
                    res_err = ERR_TOUCH_NOT_DOWN;
                end
                else
                begin
                    touch_upd   = 1'b1;
                    touch_x_new = sel_x + x_reg;
                    touch_y_new = sel_y + y_reg;
                    res_x       = touch_x_new;
                    res_y       = touch_y_new;
                    res_valid   = 1'b1;
                end
            end
            OP_TOUCH_UP:
            begin
                if (!slot_ok)
                begin
                    res_err = ERR_RANGE;
                end
                else if (!sel_present)
                begin
                    res_err = ERR_TOUCH_NOT_DOWN;
                end
                else
                begin
                    touch_upd         = 1'b1;
                    touch_x_new       = '0;
                    touch_y_new       = '0;
                    touch_present_new = 1'b0;
                end
            end
            OP_READ_KEY:
            begin
                if (!key_ok_reg)
                begin
                    res_err = ERR_RANGE;
                end
                else
                begin
                    res_state = rd_pressed ? KS_PRESSED : KS_RELEASED;
                    res_count = rd_count;
                    res_time  = rd_time;
                end
            end
            OP_READ_POS:
            begin
                if (kind_reg == KIND_MOUSE_KBD)
                begin
                    res_x     = mouse_x_reg;
                    res_y     = mouse_y_reg;
                    res_valid = mouse_present_reg;
                end
                else if ((kind_reg == KIND_TOUCH) && slot_ok)
                begin
                    res_x     = sel_x;
                    res_y     = sel_y;
                    res_valid = sel_present;
                end
                else
                begin
                    res_err = ERR_RANGE;
                end
            end
            default:
            begin
                res_err = ERR_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mouse_x_reg       <= '0;
            mouse_y_reg       <= '0;
            mouse_present_reg <= 1'b0;
            touch_present_reg <= '0;
            for (int i = 0; i < TOUCH_COUNT; i++)
            begin
                touch_x_reg[i] <= '0;
                touch_y_reg[i] <= '0;
            end
        end
        else if (cmd.finish)
        begin
            if (mouse_upd)
            begin
                mouse_x_reg       <= mouse_x_new;
                mouse_y_reg       <= mouse_y_new;
                mouse_present_reg <= 1'b1;
            end
            if (touch_upd)
            begin
                touch_x_reg[slot_idx]       <= touch_x_new;
                touch_y_reg[slot_idx]       <= touch_y_new;
                touch_present_reg[slot_idx] <= touch_present_new;
            end
        end
    end

    // output register
    logic               out_valid_reg;
    logic [1:0]         state_out_reg;
    logic [COUNT_W-1:0] count_out_reg;
    logic [TIME_W-1:0]  time_out_reg;
    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_y_reg;
    logic               pos_valid_reg;
    logic [1:0]         err_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            state_out_reg <= res_state;
            count_out_reg <= res_count;
            time_out_reg  <= res_time;
            pos_x_reg     <= res_x;
            pos_y_reg     <= res_y;
            pos_valid_reg <= res_valid;
            err_out_reg   <= res_err;
        end
    end

    assign status.clear_done = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign status.out_busy   = out_valid_reg && out_stall;

    assign out_valid     = out_valid_reg;
    assign key_state_out = state_out_reg;
    assign change_count  = count_out_reg;
    assign time_out      = time_out_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign pos_valid     = pos_valid_reg;
    assign error_code    = err_out_reg;

endmodule

`default_nettype wire

>>> rtl/input_key_and_pointer_tracker.sv
// top level of the input key and pointer tracker
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid / in_stall | operation, device_kind, device_number,
//           |           |                     | key_code, key_pressed, event_time, x/y_value
//   out     | output    | out_valid/out_stall | key_state_out, change_count, time_out,
//           |           |                     | pos_x, pos_y, pos_valid, error_code
//
// a transaction is accepted with the key memory read, then an execute
// step writes the key memory and loads the output register.
// after reset a clearing pass writes every one of the (1 + JOYSTICK_COUNT) *
// KEY_COUNT key entries (2304 at the defaults), with in_stall held high.
// a stalled result holds the execute cycle; a new transaction is still
// accepted while the previous result waits in the output register.
`default_nettype none

module input_key_and_pointer_tracker import ikpt_pkg::*; #(
    parameter int KEY_COUNT      = KEY_COUNT_DEF,
    parameter int JOYSTICK_COUNT = JOYSTICK_COUNT_DEF,
    parameter int TOUCH_COUNT    = TOUCH_COUNT_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [2:0]                operation,
    input  wire logic [1:0]                device_kind,
    input  wire logic [3:0]                device_number,
    input  wire logic [7:0]                key_code,
    input  wire logic                      key_pressed,
    input  wire logic [TIME_W-1:0]         event_time,
    input  wire logic signed [COORD_W-1:0] x_value,
    input  wire logic signed [COORD_W-1:0] y_value,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     key_state_out,
    output logic [COUNT_W-1:0]             change_count,
    output logic [TIME_W-1:0]              time_out,
    output logic signed [COORD_W-1:0]      pos_x,
    output logic signed [COORD_W-1:0]      pos_y,
    output logic                           pos_valid,
    output logic [1:0]                     error_code
);

    ikpt_cmd_t    cmd;
    ikpt_status_t status;

    ikpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    ikpt_datapath #(
        .KEY_COUNT      (KEY_COUNT),
        .JOYSTICK_COUNT (JOYSTICK_COUNT),
        .TOUCH_COUNT    (TOUCH_COUNT)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .operation     (operation),
        .device_kind   (device_kind),
        .device_number (device_number),
        .key_code      (key_code),
        .key_pressed   (key_pressed),
        .event_time    (event_time),
        .x_value       (x_value),
        .y_value       (y_value),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .key_state_out (key_state_out),
        .change_count  (change_count),
        .time_out      (time_out),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_valid     (pos_valid),
        .error_code    (error_code)
    );

endmodule

`default_nettype wire

>>> rtl/ikpt_props.sv
// port-level checks for the input key and pointer tracker, bound to the top level
`default_nettype none

module ikpt_props import ikpt_pkg::*; (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_stall,
    input wire logic                      out_valid,
    input wire logic                      out_stall,
    input wire logic [1:0]                key_state_out,
    input wire logic [COUNT_W-1:0]        change_count,
    input wire logic [TIME_W-1:0]         time_out,
    input wire logic signed [COORD_W-1:0] pos_x,
    input wire logic signed [COORD_W-1:0] pos_y,
    input wire logic                      pos_valid,
    input wire logic [1:0]                error_code
);

    // a result waiting on a stall keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(key_state_out)
            && $stable(change_count) && $stable(time_out) && $stable(pos_x)
            && $stable(pos_y) && $stable(pos_valid) && $stable(error_code))
        else $error("result changed while stalled");

    // one transaction at a time: the cycle after an accept is stalled
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("transaction accepted back to back");

    // an error result carries nothing else
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code != ERR_OK) |-> (key_state_out == KS_RELEASED)
            && (change_count == '0) && (time_out == '0) && (pos_x == '0)
            && (pos_y == '0) && !pos_valid)
        else $error("error result with nonzero fields");

    // a present pointer comes only from a pointer operation
    a_pos_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pos_valid |-> (key_state_out == KS_RELEASED)
            && (change_count == '0) && (time_out == '0) && (error_code == ERR_OK))
        else $error("pointer result mixed with key fields");

endmodule

bind input_key_and_pointer_tracker ikpt_props u_ikpt_props (.*);

`default_nettype wire

>>> tb/tracker_checker.sv
// checker for the input key and pointer tracker: predicts each result and compares it
module tracker_checker import ikpt_pkg::*; #(
    parameter int KEY_COUNT      = KEY_COUNT_DEF,
    parameter int JOYSTICK_COUNT = JOYSTICK_COUNT_DEF,
    parameter int TOUCH_COUNT    = TOUCH_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [2:0]         operation,
    input  logic [1:0]         device_kind,
    input  logic [3:0]         device_number,
    input  logic [7:0]         key_code,
    input  logic               key_pressed,
    input  logic [31:0]        event_time,
    input  logic signed [31:0] x_value,
    input  logic signed [31:0] y_value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [1:0]         key_state_out,
    input  logic [31:0]        change_count,
    input  logic [31:0]        time_out,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic               pos_valid,
    input  logic [1:0]         error_code,
    output int                 mismatches,
    output int                 pending,
    output int                 results,
    output int                 error_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KEY_DEPTH = (1 + JOYSTICK_COUNT) * KEY_COUNT;

    typedef struct packed {
        op_t                op;
        logic [1:0]         kind;
        logic [3:0]         num;
        logic [7:0]         code;
        logic               press;
        logic [31:0]        stamp;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
    } tracker_event_t;

    typedef struct packed {
        op_t                op;
        logic [1:0]         key_state;
        logic [31:0]        changes;
        logic [31:0]        stamp;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic               here;
        logic [1:0]         err;
    } tracker_report_t;

    // shadow of the block's tables
    bit                 key_down    [KEY_DEPTH];
    bit [31:0]          key_changes [KEY_DEPTH];
    bit [31:0]          key_stamp   [KEY_DEPTH];
    logic signed [31:0] mouse_x;
    logic signed [31:0] mouse_y;
    bit                 mouse_here;
    logic signed [31:0] touch_x     [TOUCH_COUNT];
    logic signed [31:0] touch_y     [TOUCH_COUNT];
    bit                 touch_here  [TOUCH_COUNT];

    tracker_report_t predicted_reports[$];
    int bad_total;
    int seen_total;
    int error_total;

    // table 0 is the mouse-keyboard, table j+1 is joystick j
    function automatic bit key_entry(input logic [1:0] kind, input logic [3:0] num,
                                     input logic [7:0] code, output int idx);
        idx = 0;
        if (int'(code) >= KEY_COUNT)
            return 1'b0;
        if (kind == KIND_MOUSE_KBD)
            idx = int'(code);
        else if (kind == KIND_JOYSTICK && int'(num) < JOYSTICK_COUNT)
            idx = (int'(num) + 1) * KEY_COUNT + int'(code);
        else
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic tracker_report_t apply_event(input tracker_event_t ev);
        tracker_report_t rep;
        int idx;
        int slot;
        bit was;
        bit again;
        rep = '0;
        rep.op = ev.op;
        slot = int'(ev.num);
        case (ev.op)
            OP_KEY:
            begin
                if (!key_entry(ev.kind, ev.num, ev.code, idx))
                    rep.err = ERR_RANGE;
                else
                begin
                    was = key_down[idx];
                    again = was && ev.press;
                    if (was != ev.press || again)
                        key_changes[idx] = key_changes[idx] + 32'd1;
                    key_down[idx] = ev.press;
                    key_stamp[idx] = ev.stamp;
                    rep.key_state = again ? KS_REPEATED
                                    : (ev.press ? KS_PRESSED : KS_RELEASED);
                    rep.changes = key_changes[idx];
                    rep.stamp = ev.stamp;
                end
            end
            OP_MOUSE_MOVE, OP_MOUSE_SET:
            begin
                // a delta on an empty mouse position becomes the position
                if (ev.op == OP_MOUSE_MOVE && mouse_here)
                begin
                    mouse_x = mouse_x + ev.dx;
                    mouse_y = mouse_y + ev.dy;
                end
                else
                begin
                    mouse_x = ev.dx;
                    mouse_y = ev.dy;
                end
                mouse_here = 1'b1;
                rep.px = mouse_x;
                rep.py = mouse_y;
                rep.here = 1'b1;
            end
            OP_TOUCH_DOWN:
            begin
                if (slot >= TOUCH_COUNT)
                    rep.err = ERR_RANGE;
                else
                begin
                    touch_x[slot] = ev.dx;
                    touch_y[slot] = ev.dy;
                    touch_here[slot] = 1'b1;
                    rep.px = ev.dx;
                    rep.py = ev.dy;
                    rep.here = 1'b1;
                end
            end
            OP_TOUCH_MOVE:
            begin
                if (slot >= TOUCH_COUNT)
                    rep.err = ERR_RANGE;
                else if (!touch_here[slot])
                    rep.err = ERR_TOUCH_NOT_DOWN;
                else
                begin
                    touch_x[slot] = touch_x[slot] + ev.dx;
                    touch_y[slot] = touch_y[slot] + ev.dy;
                    rep.px = touch_x[slot];
                    rep.py = touch_y[slot];
                    rep.here = 1'b1;
                end
            end
            OP_TOUCH_UP:
            begin
                if (slot >= TOUCH_COUNT)
                    rep.err = ERR_RANGE;
                else if (!touch_here[slot])
                    rep.err = ERR_TOUCH_NOT_DOWN;
                else
                begin
                    touch_x[slot] = '0;
                    touch_y[slot] = '0;
                    touch_here[slot] = 1'b0;
                end
            end
            OP_READ_KEY:
            begin
                if (!key_entry(ev.kind, ev.num, ev.code, idx))
                    rep.err = ERR_RANGE;
                else
                begin
                    rep.key_state = key_down[idx] ? KS_PRESSED : KS_RELEASED;
                    rep.changes = key_changes[idx];
                    rep.stamp = key_stamp[idx];
                end
            end
            default:
            begin
                if (ev.kind == KIND_MOUSE_KBD)
                begin
                    rep.px = mouse_x;
                    rep.py = mouse_y;
                    rep.here = mouse_here;
                end
                else if (ev.kind == KIND_TOUCH && slot < TOUCH_COUNT)
                begin
                    rep.px = touch_x[slot];
                    rep.py = touch_y[slot];
                    rep.here = touch_here[slot];
                end
                else
                    rep.err = ERR_RANGE;
            end
        endcase
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tracker_report_t want;
        tracker_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_DEPTH; i++)
            begin
                key_down[i] = 1'b0;
                key_changes[i] = '0;
                key_stamp[i] = '0;
            end
            for (int i = 0; i < TOUCH_COUNT; i++)
            begin
                touch_x[i] = '0;
                touch_y[i] = '0;
                touch_here[i] = 1'b0;
            end
            mouse_x = '0;
            mouse_y = '0;
            mouse_here = 1'b0;
            predicted_reports.delete();
            bad_total = 0;
            seen_total = 0;
            error_total = 0;
        end
        else
        begin
            // the result leaving now belongs to an earlier transaction, so pop first
            if (out_valid && !out_stall)
            begin
                seen_total++;
                if (predicted_reports.size() == 0)
                begin
                    bad_total++;
                    if (bad_total <= 10)
                        $display("mismatch: result with nothing expected at %0t", $realtime);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    got = '{op: want.op, key_state: key_state_out, changes: change_count,
                            stamp: time_out, px: pos_x, py: pos_y, here: pos_valid,
                            err: error_code};
                    if (got.key_state !== want.key_state || got.changes !== want.changes ||
                        got.stamp !== want.stamp || got.px !== want.px ||
                        got.py !== want.py || got.here !== want.here || got.err !== want.err)
                    begin
                        bad_total++;
                        if (bad_total <= 10)
                            $display("mismatch on %s at %0t: expected state %0d count %0d ",
                                     want.op.name(), $realtime, want.key_state, want.changes,
                                     "stamp %h pos %0d,%0d present %0d err %0d; ",
                                     want.stamp, want.px, want.py, want.here, want.err,
                                     "got state %0d count %0d stamp %h pos %0d,%0d ",
                                     got.key_state, got.changes, got.stamp, got.px, got.py,
                                     "present %0d err %0d", got.here, got.err);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                want = apply_event('{op: op_t'(operation), kind: device_kind,
                                     num: device_number, code: key_code, press: key_pressed,
                                     stamp: event_time, dx: x_value, dy: y_value});
                if (want.err != ERR_OK)
                    error_total++;
                predicted_reports.insert(predicted_reports.size(), want);
            end
        end
        mismatches <= bad_total;
        pending <= predicted_reports.size();
        results <= seen_total;
        error_results <= error_total;
    end

endmodule

>>> tb/tb_top.sv
// stimulus, idling and verdict for the input key and pointer tracker
module tb_top;
    import ikpt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 12000;
    localparam int RANDOM_ITEMS = 400;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         operation = OP_KEY;
    logic [1:0]         device_kind = KIND_MOUSE_KBD;
    logic [3:0]         device_number = '0;
    logic [7:0]         key_code = '0;
    logic               key_pressed = 1'b0;
    logic [31:0]        event_time = '0;
    logic signed [31:0] x_value = '0;
    logic signed [31:0] y_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         key_state_out;
    logic [31:0]        change_count;
    logic [31:0]        time_out;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               pos_valid;
    logic [1:0]         error_code;

    int mismatches;
    int pending;
    int results;
    int error_results;
    int sent = 0;
    int quiet_cycles = 0;
    bit calm = 1'b0;
    bit slot_down [16];

    input_key_and_pointer_tracker u_top (.*);

    tracker_checker u_checker (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic send(input op_t op, input logic [1:0] kind, input logic [3:0] num,
                        input logic [7:0] code, input logic press, input logic [31:0] stamp,
                        input logic [31:0] xv, input logic [31:0] yv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        device_kind <= kind;
        device_number <= num;
        key_code <= code;
        key_pressed <= press;
        event_time <= stamp;
        x_value <= xv;
        y_value <= yv;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
    endtask

    // hold off the next transaction until every result is back
    task automatic drain;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    function automatic logic [31:0] any_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(int'($urandom_range(0, 2000)) - 1000);
            default: return $urandom();
        endcase
    endfunction

    // most keys come from a few hot codes so presses, repeats and releases meet
    task automatic pick_key(output logic [1:0] kind, output logic [3:0] num,
                            output logic [7:0] code);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: kind = KIND_MOUSE_KBD;
            5, 6, 7, 8: kind = KIND_JOYSTICK;
            default: kind = $urandom_range(0, 1) ? KIND_TOUCH : KIND_UNUSED;
        endcase
        if (kind == KIND_JOYSTICK && $urandom_range(0, 9) != 0)
            num = 4'($urandom_range(0, 7));
        else
            num = 4'($urandom_range(0, 15));
        code = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
               : 8'($urandom_range(0, 255));
    endtask

    // receiver: random stall before each result, with calm stretches
    initial
    begin
        int hold;
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 19);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        op_t        op;
        logic [1:0] kind;
        logic [3:0] num;
        logic [7:0] code;
        logic [31:0] xv;
        logic [31:0] yv;
        int         slot;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // key table: fresh entry, press, repeat, release, release again
        send(OP_READ_KEY, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_KEY, KIND_MOUSE_KBD, 4'd15, 8'd0, 1'b1, 32'd0, '0, '0);
        send(OP_KEY, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b1, 32'd100, '0, '0);
        send(OP_KEY, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b0, 32'd200, '0, '0);
        send(OP_KEY, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b0, 32'd300, '0, '0);
        send(OP_KEY, KIND_JOYSTICK, 4'd7, 8'd255, 1'b1, 32'hffff_ffff, '1, '1);
        send(OP_READ_KEY, KIND_JOYSTICK, 4'd7, 8'd255, 1'b0, 32'd0, '0, '0);
        // devices out of range
        send(OP_KEY, KIND_JOYSTICK, 4'd8, 8'd5, 1'b1, 32'd7, '0, '0);
        send(OP_KEY, KIND_TOUCH, 4'd0, 8'd5, 1'b1, 32'd7, '0, '0);
        send(OP_READ_KEY, KIND_UNUSED, 4'd0, 8'd0, 1'b0, 32'd0, '0, '0);
        // mouse: empty read, first delta, wrapping delta, direct set
        send(OP_READ_POS, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_MOUSE_MOVE, KIND_TOUCH, 4'd9, 8'd0, 1'b0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_MOUSE_MOVE, KIND_MOUSE_KBD, 4'd0, 8'd0, 1'b0, 32'd0, 32'd1, 32'hffff_ffff);
        send(OP_MOUSE_SET, KIND_UNUSED, 4'd3, 8'd0, 1'b0, 32'd0, 32'h8000_0000, 32'h7fff_ffff);
        // touch: move and up on an empty slot, then a full down/move/up sequence
        send(OP_TOUCH_MOVE, KIND_TOUCH, 4'd3, 8'd0, 1'b0, 32'd0, 32'd5, 32'd5);
        send(OP_TOUCH_UP, KIND_TOUCH, 4'd3, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_TOUCH_DOWN, KIND_TOUCH, 4'd9, 8'd0, 1'b0, 32'd0, 32'h7fff_ffff, 32'h8000_0000);
        send(OP_TOUCH_MOVE, KIND_MOUSE_KBD, 4'd9, 8'd0, 1'b0, 32'd0, 32'd1, 32'hffff_ffff);
        send(OP_READ_POS, KIND_TOUCH, 4'd9, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_TOUCH_UP, KIND_TOUCH, 4'd9, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_READ_POS, KIND_TOUCH, 4'd9, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_TOUCH_DOWN, KIND_TOUCH, 4'd15, 8'd0, 1'b0, 32'd0, 32'd1, 32'd1);
        send(OP_READ_POS, KIND_JOYSTICK, 4'd0, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_READ_POS, KIND_UNUSED, 4'd0, 8'd0, 1'b0, 32'd0, '0, '0);
        send(OP_READ_POS, KIND_TOUCH, 4'd12, 8'd0, 1'b0, 32'd0, '0, '0);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == RANDOM_ITEMS / 2)
                drain();
            code = '0;
            kind = 2'($urandom_range(0, 3));
            num = 4'($urandom_range(0, 15));
            xv = '0;
            yv = '0;
            case ($urandom_range(0, 99)) inside
                [0:29]:
                begin
                    op = OP_KEY;
                    pick_key(kind, num, code);
                end
                [30:39]:
                begin
                    op = OP_READ_KEY;
                    pick_key(kind, num, code);
                end
                [40:51]:
                begin
                    op = $urandom_range(0, 2) ? OP_MOUSE_MOVE : OP_MOUSE_SET;
                    xv = any_coord();
                    yv = any_coord();
                end
                [52:87]:
                begin
                    slot = $urandom_range(0, 9);
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: any touch operation on any slot number
                        op = op_t'(OP_TOUCH_DOWN + $urandom_range(0, 2));
                        slot = $urandom_range(0, 15);
                    end
                    else if (!slot_down[slot])
                        op = OP_TOUCH_DOWN;
                    else
                        op = ($urandom_range(0, 3) == 0) ? OP_TOUCH_UP : OP_TOUCH_MOVE;
                    num = 4'(slot);
                    if (op == OP_TOUCH_MOVE && $urandom_range(0, 3) != 0)
                    begin
                        xv = 32'(int'($urandom_range(0, 200)) - 100);
                        yv = 32'(int'($urandom_range(0, 200)) - 100);
                    end
                    else
                    begin
                        xv = any_coord();
                        yv = any_coord();
                    end
                    if (op == OP_TOUCH_DOWN)
                        slot_down[slot] = 1'b1;
                    else if (op == OP_TOUCH_UP)
                        slot_down[slot] = 1'b0;
                end
                default:
                begin
                    op = OP_READ_POS;
                    if ($urandom_range(0, 9) != 0)
                        num = 4'($urandom_range(0, 9));
                end
            endcase
            send(op, kind, num, code, 1'($urandom_range(0, 1)), $urandom(), xv, yv);
        end

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (8) @(posedge clk);

        $display("summary: %0d transactions over all eight operations, %0d results compared",
                 sent, results);
        $display("summary: %0d error results expected, %0d mismatches", error_results,
                 mismatches);
        if (mismatches == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
